// ===== src/assert_macros.svh =====
// assertion macros for the rtl of the channel layout box parser
// no dependencies; include by bare file name inside a module body
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define CLBP_ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("clbp assertion failed");

// consequent must hold in the cycle after the antecedent
`define CLBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clbp assertion failed");

`endif

// ===== src/clbp_pkg.sv =====
// package of the channel layout box parser: parser phases, result kinds,
// register map and the result word type; no dependencies
package clbp_pkg;

  // parser phases
  localparam int unsigned PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PH_STRUCT = 3'd0;
  localparam logic [PHASE_W-1:0] PH_LAYOUT = 3'd1;
  localparam logic [PHASE_W-1:0] PH_POS    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_AZ     = 3'd3;
  localparam logic [PHASE_W-1:0] PH_EL     = 3'd4;
  localparam logic [PHASE_W-1:0] PH_MAP    = 3'd5;
  localparam logic [PHASE_W-1:0] PH_OBJ    = 3'd6;
  localparam logic [PHASE_W-1:0] PH_DONE   = 3'd7;

  // result kinds
  localparam logic [2:0] KIND_STRUCT  = 3'd0;
  localparam logic [2:0] KIND_LAYOUT  = 3'd1;
  localparam logic [2:0] KIND_CHANNEL = 3'd2;
  localparam logic [2:0] KIND_MAP     = 3'd3;
  localparam logic [2:0] KIND_OBJECT  = 3'd4;
  localparam logic [2:0] KIND_EXCESS  = 3'd5;

  localparam logic [7:0] POS_EXPLICIT  = 8'd126;
  localparam int unsigned FLAG_CHANNELS = 0;
  localparam int unsigned FLAG_OBJECTS  = 1;
  localparam logic [2:0] MAP_LAST_BYTE = 3'd7;

  // register map: a single 32-bit register, selected by the top address bit
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;
  localparam logic REG_CHANNEL_COUNT = 1'b0;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         structure_flags;
    logic [7:0]         layout_code;
    logic [7:0]         channel_index;
    logic [7:0]         speaker_position;
    logic signed [15:0] azimuth;
    logic signed [7:0]  elevation;
    logic [63:0]        omitted_map;
    logic [7:0]         object_count;
    logic               box_done;
  } clbp_res_t;

endpackage

// ===== src/clbp_in_if.sv =====
// byte input channel of the channel layout box parser
// valid/ready handshake; no dependencies
interface clbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       box_start;

  modport source (output valid, output data_byte, output box_start, input ready);
  modport sink   (input valid, input data_byte, input box_start, output ready);
endinterface

// ===== src/clbp_out_if.sv =====
// result channel of the channel layout box parser
// valid/ready handshake; no dependencies
interface clbp_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [7:0]         structure_flags;
  logic [7:0]         layout_code;
  logic [7:0]         channel_index;
  logic [7:0]         speaker_position;
  logic signed [15:0] azimuth;
  logic signed [7:0]  elevation;
  logic [63:0]        omitted_map;
  logic [7:0]         object_count;
  logic               box_done;

  modport source (
    output valid, output kind, output structure_flags, output layout_code,
    output channel_index, output speaker_position, output azimuth, output elevation,
    output omitted_map, output object_count, output box_done, input ready
  );
  modport sink (
    input valid, input kind, input structure_flags, input layout_code,
    input channel_index, input speaker_position, input azimuth, input elevation,
    input omitted_map, input object_count, input box_done, output ready
  );
endinterface

// ===== src/channel_layout_box_parser_core.sv =====
// a byte accepted passes the input register, then the result register, before
// its result word appears; bytes without a result give none
// throughput: one byte per cycle while the result channel is not stalled, set by
// the single-pass parse logic that updates the parser state between the input and result registers
// reset (rst_n, synchronous, active low) empties both registers, returns the
// parser to the structure byte and clears channel_count
module channel_layout_box_parser_core (
  input  logic                           clk,
  input  logic                           rst_n,
  clbp_in_if.sink                        in_chan,
  clbp_out_if.source                     out_chan,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [clbp_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [clbp_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [clbp_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                           cfg_pready
);
  import clbp_pkg::*;
  `include "assert_macros.svh"

  // configuration
  logic [7:0] chan_count_r;
  logic       cfg_wr;

  // input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_start_r;

  // parser state
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [7:0]         flags_r, flags_nxt;
  logic [7:0]         seen_r, seen_nxt;
  logic [2:0]         cnt_r, cnt_nxt;
  logic [63:0]        asm_r, asm_nxt;
  logic [7:0]         held_r, held_nxt;

  // state as seen by the byte in the input register (box_start restarts)
  logic [PHASE_W-1:0] phase_e;
  logic [7:0]         flags_e, seen_e, held_e;
  logic [2:0]         cnt_e;
  logic [63:0]        asm_e;

  logic               obj_flag;
  logic [PHASE_W-1:0] after_phase;
  logic [8:0]         seen_inc;
  logic               last_chan;
  logic               emit;
  clbp_res_t          res_c;

  // result register
  logic      out_valid_r;
  clbp_res_t res_r;

  logic out_room, proc;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[CFG_AW-1] == REG_CHANNEL_COUNT)
                      ? {{(CFG_DW-8){1'b0}}, chan_count_r} : '0;

  assign out_room = !out_valid_r || out_chan.ready;
  assign proc     = in_valid_r && (!emit || out_room);
  assign in_chan.ready = !in_valid_r || proc;

  always_comb begin
    phase_e = in_start_r ? PH_STRUCT : phase_r;
    flags_e = in_start_r ? 8'd0 : flags_r;
    seen_e  = in_start_r ? 8'd0 : seen_r;
    cnt_e   = in_start_r ? 3'd0 : cnt_r;
    asm_e   = in_start_r ? 64'd0 : asm_r;
    held_e  = in_start_r ? 8'd0 : held_r;

    obj_flag    = (phase_e == PH_STRUCT) ? in_byte_r[FLAG_OBJECTS] : flags_e[FLAG_OBJECTS];
    after_phase = obj_flag ? PH_OBJ : PH_DONE;
    seen_inc    = {1'b0, seen_e} + 9'd1;
    last_chan   = seen_inc >= {1'b0, chan_count_r};

    phase_nxt = phase_e;
    flags_nxt = flags_e;
    seen_nxt  = seen_e;
    cnt_nxt   = cnt_e;
    asm_nxt   = asm_e;
    held_nxt  = held_e;
    emit      = 1'b0;
    res_c     = '0;

    unique case (phase_e)
      PH_STRUCT: begin
        flags_nxt  = in_byte_r;
        emit       = 1'b1;
        res_c.kind = KIND_STRUCT;
        if (in_byte_r[FLAG_CHANNELS]) begin
          phase_nxt = PH_LAYOUT;
        end else begin
          phase_nxt      = after_phase;
          res_c.box_done = !obj_flag;
        end
      end
      PH_LAYOUT: begin
        emit              = 1'b1;
        res_c.kind        = KIND_LAYOUT;
        res_c.layout_code = in_byte_r;
        if (in_byte_r == 8'd0) begin
          seen_nxt = 8'd0;
          if (chan_count_r == 8'd0) begin
            phase_nxt      = after_phase;
            res_c.box_done = !obj_flag;
          end else begin
            phase_nxt = PH_POS;
          end
        end else begin
          held_nxt  = in_byte_r;
          asm_nxt   = 64'd0;
          cnt_nxt   = 3'd0;
          phase_nxt = PH_MAP;
        end
      end
      PH_POS: begin
        if (in_byte_r == POS_EXPLICIT) begin
          held_nxt  = in_byte_r;
          asm_nxt   = 64'd0;
          cnt_nxt   = 3'd0;
          phase_nxt = PH_AZ;
        end else begin
          emit                   = 1'b1;
          res_c.kind             = KIND_CHANNEL;
          res_c.channel_index    = seen_e;
          res_c.speaker_position = in_byte_r;
          if (last_chan) begin
            seen_nxt       = 8'd0;
            phase_nxt      = after_phase;
            res_c.box_done = !obj_flag;
          end else begin
            seen_nxt  = seen_inc[7:0];
            phase_nxt = PH_POS;
          end
        end
      end
      PH_AZ: begin
        // azimuth is kept to 16 bits, high byte first
        asm_nxt = {48'd0, asm_e[7:0], in_byte_r};
        if (cnt_e == 3'd0) begin
          cnt_nxt = 3'd1;
        end else begin
          cnt_nxt   = 3'd0;
          phase_nxt = PH_EL;
        end
      end
      PH_EL: begin
        emit                   = 1'b1;
        res_c.kind             = KIND_CHANNEL;
        res_c.channel_index    = seen_e;
        res_c.speaker_position = held_e;
        res_c.azimuth          = asm_e[15:0];
        res_c.elevation        = in_byte_r;
        if (last_chan) begin
          seen_nxt       = 8'd0;
          phase_nxt      = after_phase;
          res_c.box_done = !obj_flag;
        end else begin
          seen_nxt  = seen_inc[7:0];
          phase_nxt = PH_POS;
        end
      end
      PH_MAP: begin
        asm_nxt = {asm_e[55:0], in_byte_r};
        if (cnt_e != MAP_LAST_BYTE) begin
          cnt_nxt = cnt_e + 3'd1;
        end else begin
          cnt_nxt           = 3'd0;
          emit              = 1'b1;
          res_c.kind        = KIND_MAP;
          res_c.layout_code = held_e;
          res_c.omitted_map = {asm_e[55:0], in_byte_r};
          phase_nxt         = after_phase;
          res_c.box_done    = !obj_flag;
        end
      end
      PH_OBJ: begin
        emit               = 1'b1;
        res_c.kind         = KIND_OBJECT;
        res_c.object_count = in_byte_r;
        res_c.box_done     = 1'b1;
        phase_nxt          = PH_DONE;
      end
      PH_DONE: begin
        emit       = 1'b1;
        res_c.kind = KIND_EXCESS;
        phase_nxt  = PH_DONE;
      end
    endcase

    res_c.structure_flags = flags_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_count_r <= 8'd0;
    end else if (cfg_wr && cfg_paddr[CFG_AW-1] == REG_CHANNEL_COUNT) begin
      chan_count_r <= cfg_pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      in_valid_r <= 1'b1;
    end else if (proc) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_byte_r  <= in_chan.data_byte;
      in_start_r <= in_chan.box_start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_STRUCT;
      flags_r <= 8'd0;
      seen_r  <= 8'd0;
      cnt_r   <= 3'd0;
      held_r  <= 8'd0;
    end else if (proc) begin
      phase_r <= phase_nxt;
      flags_r <= flags_nxt;
      seen_r  <= seen_nxt;
      cnt_r   <= cnt_nxt;
      held_r  <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asm_r <= 64'd0;
    end else if (proc) begin
      asm_r <= asm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && emit) begin
      res_r <= res_c;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.kind             = res_r.kind;
  assign out_chan.structure_flags  = res_r.structure_flags;
  assign out_chan.layout_code      = res_r.layout_code;
  assign out_chan.channel_index    = res_r.channel_index;
  assign out_chan.speaker_position = res_r.speaker_position;
  assign out_chan.azimuth          = res_r.azimuth;
  assign out_chan.elevation        = res_r.elevation;
  assign out_chan.omitted_map      = res_r.omitted_map;
  assign out_chan.object_count     = res_r.object_count;
  assign out_chan.box_done         = res_r.box_done;

  // the structure phase is only ever left, never re-entered by a processed word
  `CLBP_ASSERT_NEXT(a_no_struct_after_proc, clk, rst_n, proc, phase_r != PH_STRUCT)
  // a done result parks the parser in the excess phase
  `CLBP_ASSERT_NEXT(a_done_parks, clk, rst_n, proc && emit && res_c.box_done,
                    phase_r == PH_DONE)
  // the byte counter only runs while assembling angles or the map
  `CLBP_ASSERT_ALWAYS(a_cnt_phase, clk, rst_n,
                      cnt_r == 3'd0 || phase_r == PH_AZ || phase_r == PH_MAP)
  // excess words never carry the done flag
  `CLBP_ASSERT_ALWAYS(a_excess_not_done, clk, rst_n,
                      !(out_valid_r && res_r.kind == KIND_EXCESS) || !res_r.box_done)

endmodule
